### sv/assert_macros.svh
// Assertion macros for the checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### sv/fcr_pkg.sv
// Types and constants of the framed command receiver.
package fcr_pkg;

  localparam int DATA_BYTES   = 29;
  localparam int PAYLOAD_LEN  = 1 + DATA_BYTES;
  localparam int POS_CMD      = 3;
  localparam int POS_CHECK    = 4 + DATA_BYTES;
  localparam int POS_FOOT0    = POS_CHECK + 1;
  localparam int POS_FOOT1    = POS_CHECK + 2;
  localparam int POS_W        = $clog2(POS_FOOT1 + 1);
  localparam int PAY_IDX_W    = $clog2(PAYLOAD_LEN);
  localparam int BYTE_INDEX_W = 5;
  localparam int STATUS_W     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int LIMIT_RESET  = 30;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPT  = 3'd0,
    STAT_DROP    = 3'd1,
    STAT_REJECT  = 3'd2,
    STAT_FRAME   = 3'd3,
    STAT_RELEASE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER = 2'd0,
    REG_FOOTER = 2'd1,
    REG_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic next_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic run_start;
    logic out_last;
  } dp_sts_t;

endpackage

### sv/fcr_ctrl.sv
// Controller state machine of the framed command receiver.
module fcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  fcr_pkg::dp_sts_t sts,
  output logic             in_ready,
  output logic             out_valid,
  output fcr_pkg::dp_cmd_t cmd
);

  fcr_pkg::state_t state;
  fcr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fcr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sts.run_start ? fcr_pkg::S_EMIT : fcr_pkg::S_RESP;
        end
      end
      fcr_pkg::S_RESP: begin
        if (out_ready) begin
          state_next = fcr_pkg::S_IDLE;
        end
      end
      fcr_pkg::S_EMIT: begin
        if (out_ready && sts.out_last) begin
          state_next = fcr_pkg::S_IDLE;
        end
      end
      default: state_next = fcr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load_item = 1'b0;
    cmd.next_byte = 1'b0;
    unique case (state)
      fcr_pkg::S_IDLE: begin
        in_ready      = !rst;
        cmd.load_item = in_valid && !rst;
      end
      fcr_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      fcr_pkg::S_EMIT: begin
        out_valid     = 1'b1;
        cmd.next_byte = out_ready && !sts.out_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/fcr_dp.sv
// Datapath of the framed command receiver: parser state, payload store and result register.
module fcr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              mode,
  input  logic [7:0]                        rx_byte,
  input  fcr_pkg::dp_cmd_t                  cmd,
  output fcr_pkg::dp_sts_t                  sts,
  output fcr_pkg::status_t                  status,
  output logic [7:0]                        frame_byte,
  output logic [fcr_pkg::BYTE_INDEX_W-1:0]  byte_index,
  output logic [7:0]                        length_value,
  output logic                              last
);

  logic [7:0] header_byte;
  logic [7:0] footer_byte;
  logic [7:0] length_limit;

  logic [fcr_pkg::POS_W-1:0]     position;
  logic [fcr_pkg::POS_W-1:0]     position_next;
  logic                          frame_held;
  logic                          frame_held_next;
  logic [7:0]                    length_store;
  logic [7:0]                    length_store_next;
  logic [7:0]                    running_xor;
  logic [7:0]                    running_xor_next;
  logic [7:0]                    hdr_seen [2];
  logic [7:0]                    payload_store [fcr_pkg::PAYLOAD_LEN];
  logic                          pay_we;
  logic [fcr_pkg::PAY_IDX_W-1:0] pay_widx;
  logic                          hdr_we;
  logic [fcr_pkg::PAY_IDX_W-1:0] emit_cnt;
  logic [fcr_pkg::PAY_IDX_W-1:0] emit_cnt_next;
  fcr_pkg::status_t              res_status;
  logic                          run_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= '0;
      footer_byte  <= '0;
      length_limit <= 8'(fcr_pkg::LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcr_pkg::REG_HEADER: header_byte  <= cfg_data;
        fcr_pkg::REG_FOOTER: footer_byte  <= cfg_data;
        fcr_pkg::REG_LIMIT:  length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    position_next     = position;
    frame_held_next   = frame_held;
    length_store_next = length_store;
    running_xor_next  = running_xor;
    pay_we            = 1'b0;
    hdr_we            = 1'b0;
    pay_widx          = fcr_pkg::PAY_IDX_W'(position - fcr_pkg::POS_W'(fcr_pkg::POS_CMD));
    res_status        = fcr_pkg::STAT_ACCEPT;
    run_start         = 1'b0;
    if (mode) begin
      frame_held_next = 1'b0;
      res_status      = fcr_pkg::STAT_RELEASE;
    end else if (frame_held) begin
      res_status = fcr_pkg::STAT_DROP;
    end else if (position <= fcr_pkg::POS_W'(1)) begin
      if (rx_byte == header_byte) begin
        hdr_we        = 1'b1;
        position_next = position + 1'b1;
      end else begin
        res_status = fcr_pkg::STAT_REJECT;
      end
    end else if (position == fcr_pkg::POS_W'(2)) begin
      if (hdr_seen[0] == header_byte && hdr_seen[1] == header_byte &&
          rx_byte != 8'd0 && rx_byte < length_limit) begin
        length_store_next = rx_byte;
        position_next     = position + 1'b1;
      end else begin
        res_status = fcr_pkg::STAT_REJECT;
      end
    end else if (position < fcr_pkg::POS_W'(fcr_pkg::POS_CHECK)) begin
      pay_we           = 1'b1;
      running_xor_next = (position == fcr_pkg::POS_W'(fcr_pkg::POS_CMD)) ?
                         rx_byte : (running_xor ^ rx_byte);
      position_next    = position + 1'b1;
    end else if (position == fcr_pkg::POS_W'(fcr_pkg::POS_CHECK)) begin
      if (rx_byte == ~running_xor) begin
        position_next = position + 1'b1;
      end else begin
        res_status = fcr_pkg::STAT_REJECT;
      end
    end else if (position == fcr_pkg::POS_W'(fcr_pkg::POS_FOOT0)) begin
      if (rx_byte == footer_byte) begin
        position_next = position + 1'b1;
      end else begin
        res_status = fcr_pkg::STAT_REJECT;
      end
    end else if (position == fcr_pkg::POS_W'(fcr_pkg::POS_FOOT1) &&
                 rx_byte == footer_byte) begin
      position_next   = '0;
      frame_held_next = 1'b1;
      res_status      = fcr_pkg::STAT_FRAME;
      run_start       = 1'b1;
    end else begin
      res_status = fcr_pkg::STAT_REJECT;
    end
    if (res_status == fcr_pkg::STAT_REJECT) begin
      position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      frame_held   <= 1'b0;
      length_store <= '0;
      running_xor  <= '0;
      hdr_seen[0]  <= '0;
      hdr_seen[1]  <= '0;
    end else if (cmd.load_item) begin
      position     <= position_next;
      frame_held   <= frame_held_next;
      length_store <= length_store_next;
      running_xor  <= running_xor_next;
      if (hdr_we) begin
        hdr_seen[position[0]] <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && pay_we) begin
      payload_store[pay_widx] <= rx_byte;
    end
  end

  assign emit_cnt_next = emit_cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      emit_cnt <= '0;
      status   <= res_status;
      if (run_start) begin
        frame_byte   <= payload_store[0];
        byte_index   <= '0;
        length_value <= length_store;
        last         <= 1'b0;
      end else begin
        frame_byte   <= '0;
        byte_index   <= '0;
        length_value <= '0;
        last         <= 1'b1;
      end
    end else if (cmd.next_byte) begin
      emit_cnt   <= emit_cnt_next;
      frame_byte <= payload_store[emit_cnt_next];
      byte_index <= fcr_pkg::BYTE_INDEX_W'(emit_cnt_next);
      last       <= (emit_cnt_next == fcr_pkg::PAY_IDX_W'(fcr_pkg::PAYLOAD_LEN - 1));
    end
  end

  assign sts.run_start = run_start;
  assign sts.out_last  = last;

endmodule

### sv/framed_command_receiver.sv
// Top level of the framed command receiver.
// The block checks received bytes against a frame of two header bytes, a length byte, a
// command byte, 29 data bytes, an inverted-XOR check byte and two footer bytes, and answers
// every input item with one result, except the last footer byte of a good frame, which
// starts a run of 30 results (command, then data bytes) sent one per cycle while the output
// is ready, with tlast on the final one. After such a run the block drops bytes until a
// release item arrives. The controller works on one input item at a time: an item is taken,
// its result is offered from the next cycle, and the next item is taken in the cycle after
// that result is accepted.
module framed_command_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // rx_byte
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // frame_byte, byte_index, length_value
  output logic [2:0]                    m_axis_tuser,  // status
  output logic                          m_axis_tlast
);

  fcr_pkg::dp_cmd_t                 cmd;
  fcr_pkg::dp_sts_t                 sts;
  fcr_pkg::status_t                 status;
  logic [7:0]                       frame_byte;
  logic [fcr_pkg::BYTE_INDEX_W-1:0] byte_index;
  logic [7:0]                       length_value;

  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  fcr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (s_axis_tuser),
    .rx_byte      (s_axis_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .length_value (length_value),
    .last         (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, length_value, byte_index, frame_byte};
  assign m_axis_tuser = status;

endmodule

### sv/fcr_checker.sv
// Port-level checker of the framed command receiver and its bind statement.
`include "assert_macros.svh"

module fcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        in_fire;
  logic        out_fire;
  logic        out_stall;
  logic        status_ok;
  logic        run_more;
  logic        frame_out;
  logic [27:0] out_word;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign status_ok = m_axis_tuser <= fcr_pkg::STAT_RELEASE;
  assign run_more  = out_fire && m_axis_tuser == fcr_pkg::STAT_FRAME && !m_axis_tlast;
  assign frame_out = m_axis_tvalid && m_axis_tuser == fcr_pkg::STAT_FRAME;
  assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  `ASSERT_NEVER(a_no_overlap, clk, rst, in_fire && m_axis_tvalid, "item taken while a result waits")
  `ASSERT_PROP(a_result_follows, clk, rst, in_fire |=> m_axis_tvalid, "no result after an item")
  `ASSERT_PROP(a_status_range, clk, rst, m_axis_tvalid |-> status_ok, "status out of range")
  `ASSERT_PROP(a_run_continues, clk, rst, run_more |=> frame_out, "frame run broken")
  `ASSERT_PROP(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled result changed")

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (.*);
